### sv/cfb_pkg.sv
// Shared types, constants and the CRC-8 byte function of the command frame builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package cfb_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 7;
	localparam int IDX_W   = 8;
	localparam int POS_W   = 4;

	// Reflected Maxim polynomial
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
	localparam logic [IDX_W-1:0] REG_SYNC_SECOND = 8'd1;
	localparam logic [IDX_W-1:0] REG_DEST_ADDR   = 8'd2;
	localparam logic [IDX_W-1:0] REG_SRC_ADDR    = 8'd3;

	// Register reset values
	localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'h06;
	localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'h85;
	localparam logic [BYTE_W-1:0] RST_DEST_ADDR   = 8'h04;
	localparam logic [BYTE_W-1:0] RST_SRC_ADDR    = 8'h01;

	// Byte positions within one message's run; a message inside a frame starts at POS_ADDR
	localparam logic [POS_W-1:0] POS_SYNC1 = 4'd0;
	localparam logic [POS_W-1:0] POS_SYNC2 = 4'd1;
	localparam logic [POS_W-1:0] POS_DEST  = 4'd2;
	localparam logic [POS_W-1:0] POS_SRC   = 4'd3;
	localparam logic [POS_W-1:0] POS_LEN   = 4'd4;
	localparam logic [POS_W-1:0] POS_ADDR  = 4'd5;
	localparam logic [POS_W-1:0] POS_LO    = 4'd6;
	localparam logic [POS_W-1:0] POS_HI    = 4'd7;
	localparam logic [POS_W-1:0] POS_CRC   = 4'd8;

	typedef struct packed {
		logic [BYTE_W-1:0]  msg_address;
		logic [BYTE_W-1:0]  value_low;
		logic [BYTE_W-1:0]  value_high;
		logic [COUNT_W-1:0] message_count;
	} msg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [BYTE_W-1:0] dest_addr;
		logic [BYTE_W-1:0] src_addr;
	} cfg_t;

	// One byte through the reflected CRC, LSB first
	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		logic [BYTE_W-1:0] d;
		c = crc;
		d = data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### sv/cfb_ifs.sv
// Valid/ready channel interfaces: command messages in, frame bytes out, register writes.
// Depends on cfb_pkg for widths.
`default_nettype none
interface cfb_msg_if;
	import cfb_pkg::*;
	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  msg_address;
	logic [BYTE_W-1:0]  value_low;
	logic [BYTE_W-1:0]  value_high;
	logic [COUNT_W-1:0] message_count;
	modport source (output valid, msg_address, value_low, value_high, message_count,
		input ready);
	modport sink (input valid, msg_address, value_low, value_high, message_count,
		output ready);
endinterface

interface cfb_byte_if;
	import cfb_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;
	logic              frame_last;
	modport source (output valid, out_byte, run_last, frame_last, input ready);
	modport sink (input valid, out_byte, run_last, frame_last, output ready);
endinterface

interface cfb_cfg_if;
	import cfb_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [BYTE_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/command_frame_builder_crc8_core.sv
// Top level of the command frame builder: register block, input register, sequencer.
// Depends on cfb_pkg, cfb_ifs, cfb_cfg_regs, cfb_in_reg and cfb_sequencer.
//
// Each command word (address, value low, value high) becomes three bytes on the frame
// channel, one byte per cycle while the channel is ready. The first word of a frame
// samples message_count (zero counts as one) and is preceded by the header: two sync
// bytes, destination, source and a length byte of three times the count, low 8 bits.
// After the last word of the frame a reflected CRC-8 (poly 0x8C, init 0) over the
// message bytes follows, flagged by frame_last; run_last marks the final byte of each
// word's run. The byte sequencer is the limit: a run is three bytes, plus five header
// bytes when it opens a frame and the CRC when it closes one. The input register
// takes the next word while the current run drains, so runs follow without gaps.
`default_nettype none
module command_frame_builder_crc8_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cfb_msg_if.sink     msg,
	cfb_byte_if.source  frame,
	cfb_cfg_if.sink     cfg
);
	import cfb_pkg::*;

	cfg_t regs;
	logic s1_valid;
	msg_t s1_msg;
	logic load;

	cfb_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	cfb_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg      (msg),
		.load     (load),
		.s1_valid (s1_valid),
		.s1_msg   (s1_msg)
	);

	cfb_sequencer u_sequencer (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.s1_valid (s1_valid),
		.s1_msg   (s1_msg),
		.load     (load),
		.frame    (frame)
	);

endmodule
`default_nettype wire

### sv/cfb_cfg_regs.sv
// Header configuration registers written through the register write channel.
// Depends on cfb_pkg and cfb_cfg_if.
`default_nettype none
module cfb_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cfb_cfg_if.sink            cfg,
	output cfb_pkg::cfg_t      regs
);
	import cfb_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Register decode; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.sync_first  <= RST_SYNC_FIRST;
			regs_q.sync_second <= RST_SYNC_SECOND;
			regs_q.dest_addr   <= RST_DEST_ADDR;
			regs_q.src_addr    <= RST_SRC_ADDR;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SYNC_FIRST:  regs_q.sync_first  <= cfg.data;
				REG_SYNC_SECOND: regs_q.sync_second <= cfg.data;
				REG_DEST_ADDR:   regs_q.dest_addr   <= cfg.data;
				REG_SRC_ADDR:    regs_q.src_addr    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/cfb_in_reg.sv
// Input register holding one command message until the sequencer picks it up.
// Depends on cfb_pkg and cfb_msg_if.
`default_nettype none
module cfb_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cfb_msg_if.sink            msg,
	input  wire logic          load,
	output logic               s1_valid,
	output cfb_pkg::msg_t      s1_msg
);
	import cfb_pkg::*;

	logic valid_s1;
	msg_t msg_s1;

	// Free slot, or the held word leaves this cycle
	assign msg.ready = !valid_s1 || load;
	assign s1_valid  = valid_s1;
	assign s1_msg    = msg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			msg_s1.msg_address   <= msg.msg_address;
			msg_s1.value_low     <= msg.value_low;
			msg_s1.value_high    <= msg.value_high;
			msg_s1.message_count <= msg.message_count;
		end
	end

endmodule
`default_nettype wire

### sv/cfb_sequencer.sv
// Frame state, byte sequencer, running CRC and output register.
// Depends on cfb_pkg and cfb_byte_if.
`default_nettype none
module cfb_sequencer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfb_pkg::cfg_t regs,
	input  wire logic          s1_valid,
	input  wire cfb_pkg::msg_t s1_msg,
	output logic               load,
	cfb_byte_if.source         frame
);
	import cfb_pkg::*;

	// Frame state
	logic               in_frame_q;
	logic [COUNT_W-1:0] left_q;
	logic [BYTE_W-1:0]  crc_q;

	// Current message run
	logic               busy_q;
	logic [POS_W-1:0]   pos_q;
	logic               close_q;
	logic [BYTE_W-1:0]  addr_q;
	logic [BYTE_W-1:0]  lo_q;
	logic [BYTE_W-1:0]  hi_q;
	logic [BYTE_W-1:0]  len_q;
	cfg_t               hdr_q;

	// Output register
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               run_last_q;
	logic               frame_last_q;

	logic               out_adv;
	logic               emit;
	logic [POS_W-1:0]   last_pos;
	logic               run_end;
	logic [BYTE_W-1:0]  cur_byte;
	logic               is_msg_byte;
	logic [COUNT_W-1:0] count_fix;
	logic [COUNT_W-1:0] left_next;
	logic               close_next;
	logic [BYTE_W-1:0]  len_next;

	assign out_adv  = !out_valid_q || frame.ready;
	assign emit     = busy_q && out_adv;
	assign last_pos = close_q ? POS_CRC : POS_HI;
	assign run_end  = emit && (pos_q == last_pos);
	assign load     = s1_valid && (!busy_q || run_end);

	// Opening message: zero count counts as one
	assign count_fix  = (s1_msg.message_count == '0) ? COUNT_W'(1) : s1_msg.message_count;
	assign left_next  = in_frame_q ? (left_q - COUNT_W'(1)) : (count_fix - COUNT_W'(1));
	assign close_next = (left_next == '0);
	assign len_next   = BYTE_W'({1'b0, count_fix}) + BYTE_W'({count_fix, 1'b0});

	// Byte select by position
	always_comb begin
		is_msg_byte = 1'b0;
		unique case (pos_q)
			POS_SYNC1: cur_byte = hdr_q.sync_first;
			POS_SYNC2: cur_byte = hdr_q.sync_second;
			POS_DEST:  cur_byte = hdr_q.dest_addr;
			POS_SRC:   cur_byte = hdr_q.src_addr;
			POS_LEN:   cur_byte = len_q;
			POS_ADDR: begin
				cur_byte    = addr_q;
				is_msg_byte = 1'b1;
			end
			POS_LO: begin
				cur_byte    = lo_q;
				is_msg_byte = 1'b1;
			end
			POS_HI: begin
				cur_byte    = hi_q;
				is_msg_byte = 1'b1;
			end
			POS_CRC:   cur_byte = crc_q;
			default:   cur_byte = crc_q;
		endcase
	end

	// Control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			left_q     <= '0;
			crc_q      <= CRC_INIT;
			busy_q     <= 1'b0;
			pos_q      <= POS_SYNC1;
			close_q    <= 1'b0;
		end else begin
			// crc advances one message byte per cycle while bytes are emitted, clears after the closing byte
			if (emit && is_msg_byte) begin
				crc_q <= crc8_byte(crc_q, cur_byte);
			end else if (emit && pos_q == POS_CRC) begin
				crc_q <= CRC_INIT;
			end
			if (load) begin
				busy_q     <= 1'b1;
				pos_q      <= in_frame_q ? POS_ADDR : POS_SYNC1;
				close_q    <= close_next;
				left_q     <= left_next;
				in_frame_q <= !close_next;
			end else if (run_end) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// Message payload and header snapshot
	always_ff @(posedge clk) begin
		if (load) begin
			addr_q <= s1_msg.msg_address;
			lo_q   <= s1_msg.value_low;
			hi_q   <= s1_msg.value_high;
			len_q  <= len_next;
			hdr_q  <= regs;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= cur_byte;
			run_last_q   <= (pos_q == last_pos);
			frame_last_q <= (pos_q == POS_CRC);
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.out_byte   = out_byte_q;
	assign frame.run_last   = run_last_q;
	assign frame.frame_last = frame_last_q;

endmodule
`default_nettype wire

### sim/cfb_frame_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the command frame builder: predicts the byte stream from accepted words
// and register writes, then checks every accepted frame byte. Depends on cfb_pkg, cfb_ifs.
module cfb_frame_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	cfb_msg_if        msg,
	cfb_byte_if       frame,
	cfb_cfg_if        cfg,
	output int        mismatches,
	output int        pending
);
	import cfb_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              run_end;
		logic              frame_end;
	} frame_byte_t;

	// Shadow of the header registers and the framing state
	cfg_t               hdr_regs;
	logic               frame_open;
	logic [COUNT_W-1:0] words_left;
	logic [BYTE_W-1:0]  crc_acc;
	frame_byte_t        expected_bytes[$];
	int                 err_cnt = 0;

	assign mismatches = err_cnt;

	// Reflected CRC-8, data folded in first and then shifted out bit by bit
	function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		r = crc ^ b;
		for (int i = 0; i < BYTE_W; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
		input logic [BYTE_W-1:0] want);
		$display("mismatch at %0t: %0s got 0x%02h want 0x%02h", $realtime, what, got, want);
		err_cnt++;
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic closes);
		frame_byte_t fb;
		fb.data      = b;
		fb.run_end   = 1'b0;
		fb.frame_end = closes;
		expected_bytes.push_back(fb);
	endtask

	// Expected bytes of one accepted word: header if it opens a frame, its three bytes,
	// and the CRC if it closes the frame
	task automatic predict_frame_bytes(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] lo,
		input logic [BYTE_W-1:0] hi, input logic [COUNT_W-1:0] cnt);
		logic [COUNT_W-1:0] n;
		logic [BYTE_W-1:0]  len;
		if (!frame_open) begin
			// zero count means a single-word frame
			n   = (cnt == '0) ? COUNT_W'(1) : cnt;
			len = BYTE_W'(3 * int'(n));
			push_byte(hdr_regs.sync_first, 1'b0);
			push_byte(hdr_regs.sync_second, 1'b0);
			push_byte(hdr_regs.dest_addr, 1'b0);
			push_byte(hdr_regs.src_addr, 1'b0);
			push_byte(len, 1'b0);
			crc_acc    = CRC_INIT;
			words_left = n;
			frame_open = 1'b1;
		end
		push_byte(a, 1'b0);
		push_byte(lo, 1'b0);
		push_byte(hi, 1'b0);
		crc_acc    = crc8_step(crc_acc, a);
		crc_acc    = crc8_step(crc_acc, lo);
		crc_acc    = crc8_step(crc_acc, hi);
		words_left = words_left - 1'b1;
		if (words_left == '0) begin
			push_byte(crc_acc, 1'b1);
			frame_open = 1'b0;
			crc_acc    = CRC_INIT;
		end
		expected_bytes[expected_bytes.size() - 1].run_end = 1'b1;
	endtask

	task automatic compare_frame_byte();
		frame_byte_t want;
		if (expected_bytes.size() == 0) begin
			report_mismatch("byte with nothing expected", frame.out_byte, '0);
		end else begin
			want = expected_bytes.pop_front();
			if (frame.out_byte !== want.data) begin
				report_mismatch("out_byte", frame.out_byte, want.data);
			end
			if (frame.run_last !== want.run_end) begin
				report_mismatch("run_last", BYTE_W'(frame.run_last), BYTE_W'(want.run_end));
			end
			if (frame.frame_last !== want.frame_end) begin
				report_mismatch("frame_last", BYTE_W'(frame.frame_last), BYTE_W'(want.frame_end));
			end
		end
	endtask

	// Watch all three channels; words go in before bytes are checked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_regs.sync_first  = RST_SYNC_FIRST;
			hdr_regs.sync_second = RST_SYNC_SECOND;
			hdr_regs.dest_addr   = RST_DEST_ADDR;
			hdr_regs.src_addr    = RST_SRC_ADDR;
			frame_open           = 1'b0;
			words_left           = '0;
			crc_acc              = CRC_INIT;
			expected_bytes.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SYNC_FIRST: begin
						hdr_regs.sync_first = cfg.data;
					end
					REG_SYNC_SECOND: begin
						hdr_regs.sync_second = cfg.data;
					end
					REG_DEST_ADDR: begin
						hdr_regs.dest_addr = cfg.data;
					end
					REG_SRC_ADDR: begin
						hdr_regs.src_addr = cfg.data;
					end
					default: begin
					end
				endcase
			end
			if (msg.valid && msg.ready) begin
				predict_frame_bytes(msg.msg_address, msg.value_low, msg.value_high,
					msg.message_count);
			end
			if (frame.valid && frame.ready) begin
				compare_frame_byte();
			end
			pending <= expected_bytes.size();
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the command frame builder testbench: clock, reset, words, register writes and
// output back-pressure. Depends on cfb_pkg, cfb_ifs, the core and cfb_frame_checker.
module tb_top;
	import cfb_pkg::*;

	localparam int STALL_PCT      = 34;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_WORDS    = 35;
	localparam int PHASES         = 4;
	localparam int DRAIN_CYCLES   = 20;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic steady = 1'b0;
	logic sink_ready = 1'b0;
	int   quiet_cycles = 0;
	int   words_sent;
	int   mismatches;
	int   pending;

	cfb_msg_if  msg_ch();
	cfb_byte_if frame_ch();
	cfb_cfg_if  cfg_ch();

	command_frame_builder_crc8_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.frame  (frame_ch),
		.cfg    (cfg_ch)
	);

	cfb_frame_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg_ch),
		.frame      (frame_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Byte sink back-pressure
	always @(posedge clk) begin
		sink_ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
	end
	assign frame_ch.ready = sink_ready;

	// Watchdog on stretches with no handshake anywhere
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((msg_ch.valid && msg_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One word on the message channel; valid stays up for a following word
	task automatic send_word(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] lo,
		input logic [BYTE_W-1:0] hi, input logic [COUNT_W-1:0] cnt);
		while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
			msg_ch.valid         <= 1'b0;
			msg_ch.msg_address   <= BYTE_W'($urandom);
			msg_ch.value_low     <= BYTE_W'($urandom);
			msg_ch.value_high    <= BYTE_W'($urandom);
			msg_ch.message_count <= COUNT_W'($urandom);
			@(posedge clk);
		end
		msg_ch.valid         <= 1'b1;
		msg_ch.msg_address   <= a;
		msg_ch.value_low     <= lo;
		msg_ch.value_high    <= hi;
		msg_ch.message_count <= cnt;
		@(posedge clk);
		while (!msg_ch.ready) begin
			@(posedge clk);
		end
		words_sent++;
	endtask

	// Drop valid after the last word and wait for every predicted byte
	task automatic drain();
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
		while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
			@(posedge clk);
		end
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// All header registers, plus a write to an unmapped index that must be dropped
	task automatic write_header(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
		input logic [BYTE_W-1:0] dst, input logic [BYTE_W-1:0] src);
		write_reg(REG_SYNC_FIRST, s1);
		write_reg(REG_SYNC_SECOND, s2);
		write_reg(REG_DEST_ADDR, dst);
		write_reg(REG_SRC_ADDR, src);
		write_reg(IDX_W'($urandom_range(4, 255)), BYTE_W'($urandom));
	endtask

	// A whole frame of random words; later words carry a junk count
	task automatic send_frame(input logic [COUNT_W-1:0] cnt_field);
		int n;
		n = (cnt_field == '0) ? 1 : int'(cnt_field);
		send_word(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), cnt_field);
		for (int i = 1; i < n; i++) begin
			send_word(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
				COUNT_W'($urandom));
		end
	endtask

	initial begin
		int pick;
		msg_ch.valid         <= 1'b0;
		msg_ch.msg_address   <= '0;
		msg_ch.value_low     <= '0;
		msg_ch.value_high    <= '0;
		msg_ch.message_count <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.index         <= '0;
		cfg_ch.data          <= '0;
		words_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset header values, single-word frame and a zero count
		send_word(8'h00, 8'h00, 8'h00, COUNT_W'(1));
		send_word(8'hFF, 8'hFF, 8'hFF, '0);
		drain();

		// All-zero header, then a two-word frame with extreme bytes
		write_header(8'h00, 8'h00, 8'h00, 8'h00);
		write_reg(8'hFF, 8'hAA);
		send_word(8'hFF, 8'h00, 8'hFF, COUNT_W'(2));
		send_word(8'h00, 8'hFF, 8'h00, 7'h7F);
		drain();

		// All-ones header; registers rewritten in the middle of a frame
		write_header(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_word(8'h80, 8'h01, 8'h7F, COUNT_W'(3));
		drain();
		write_reg(REG_SYNC_FIRST, 8'h5A);
		write_reg(REG_DEST_ADDR, 8'hC3);
		send_word(8'h01, 8'h80, 8'hFE, '0);
		send_word(8'h55, 8'hAA, 8'h33, 7'h40);
		send_word(8'h7F, 8'hFE, 8'h01, COUNT_W'(4));
		send_word(8'hA5, 8'h5A, 8'hC3, 7'h00);
		send_word(8'h3C, 8'hC3, 8'h96, 7'h2A);
		send_word(8'hFE, 8'h7F, 8'h80, 7'h55);
		drain();

		// Random phases, each with its own header settings
		for (int p = 0; p < PHASES; p++) begin
			steady <= (p == 2);
			write_header(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
				BYTE_W'($urandom));
			words_sent = 0;
			// one frame long enough that the length byte wraps
			if (p == 1) begin
				send_frame(COUNT_W'($urandom_range(86, 127)));
			end
			while (words_sent < PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					send_frame('0);
				end else if (pick < 10) begin
					send_frame(COUNT_W'($urandom_range(10, 40)));
				end else begin
					send_frame(COUNT_W'($urandom_range(1, 6)));
				end
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
